FILE: src/jav_pkg.sv
// Shared constants, types and helpers for the joint attractor velocity controller.
package jav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int JOINTS    = 16;
  localparam int NGAIN     = 13;
  localparam int JOINT_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int GADDR_W   = $clog2(JOINTS * NGAIN);
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 64;

  localparam logic signed [31:0] QONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [63:0] DEAD_THR = ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10;

  // floor(2^40 / 1000): reciprocal for the divide by 1000 of the period scaling
  localparam logic [31:0] RCP_1000 = 32'd1099511627;

  // gain slots per joint
  localparam logic [3:0] G_MIN     = 4'd0;
  localparam logic [3:0] G_MAX     = 4'd1;
  localparam logic [3:0] G_W       = 4'd2;
  localparam logic [3:0] G_K       = 4'd3;
  localparam logic [3:0] G_C       = 4'd4;
  localparam logic [3:0] G_FXMAX   = 4'd5;
  localparam logic [3:0] G_KFLIM   = 4'd6;
  localparam logic [3:0] G_FLIMMAX = 4'd7;
  localparam logic [3:0] G_FCSTMAX = 4'd8;
  localparam logic [3:0] G_KFFLD   = 4'd9;
  localparam logic [3:0] G_FFLDMAX = 4'd10;
  localparam logic [3:0] G_KFRPC   = 4'd11;
  localparam logic [3:0] G_FRPCMAX = 4'd12;

  typedef enum logic [2:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_ATTRACTOR  = 3'd1,
    CMD_CONSTRAINT = 3'd2,
    CMD_FIELD      = 3'd3,
    CMD_EXTERNAL   = 3'd4,
    CMD_GAIN       = 3'd5
  } cmd_t;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_DRIVE  = 1'b1;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647)       r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else                           r = 32'(x);
    return r;
  endfunction

endpackage

FILE: src/jav_mul.sv
// Shared signed multiplier with registered product.
module jav_mul (
  input  logic                              clk,
  input  logic signed [jav_pkg::MUL_W-1:0]  a,
  input  logic signed [jav_pkg::MUL_W-1:0]  b,
  output logic signed [jav_pkg::PROD_W-1:0] prod
);
  import jav_pkg::*;

  logic signed [2*MUL_W-1:0] full;

  assign full = (2*MUL_W)'(a) * (2*MUL_W)'(b);

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

FILE: src/jav_div.sv
// Shared radix-2 restoring divider: 64-bit signed by 64-bit signed, saturated 32-bit quotient.
module jav_div (
  input  logic                   clk,
  input  logic                   rst,
  input  jav_pkg::div_req_t      req,
  output logic                   busy,
  output logic                   done,
  output logic signed [31:0]     quo
);
  import jav_pkg::*;

  logic [63:0] nmag;
  logic [63:0] dmag;
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic        fin;
  logic [64:0] rem_sh;
  logic        qbit;

  assign rem_sh = {rem, nmag[63]};
  assign qbit   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      fin  <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (req.start) begin
        if (req.den == 64'sd0) begin
          // divide by zero saturates by the sign of the numerator
          if (req.num > 64'sd0)      quo <= 32'sh7fffffff;
          else if (req.num < 64'sd0) quo <= 32'sh80000000;
          else                       quo <= 32'sd0;
          done <= 1'b1;
        end else begin
          nmag <= req.num[63] ? 64'(-req.num) : 64'(req.num);
          dmag <= req.den[63] ? 64'(-req.den) : 64'(req.den);
          neg  <= req.num[63] ^ req.den[63];
          rem  <= 64'd0;
          cnt  <= 6'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= qbit ? 64'(rem_sh - {1'b0, dmag}) : rem_sh[63:0];
        nmag <= {nmag[62:0], qbit};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        // truncation toward zero, then saturate
        if (neg) begin
          if (nmag > 64'h0000_0000_8000_0000) quo <= 32'sh80000000;
          else                                quo <= 32'(-nmag[31:0]);
        end else begin
          if (nmag > 64'h0000_0000_7fff_ffff) quo <= 32'sh7fffffff;
          else                                quo <= 32'(nmag[31:0]);
        end
        done <= 1'b1;
      end
    end
  end

endmodule

FILE: src/joint_attractor_velocity_control_unit.sv
// Top level of the joint attractor velocity controller: sequencer, state and gain memory.
// One item is taken at a time. A sample (cmd 0) loads the joint's 13 gains from the gain
// memory, then runs up to five divisions on the shared 64-step divider (a zero divisor is
// answered without iterating; the limit-zone division is skipped when the position is
// clear of both limit zones) and seven products on the shared multiplier. The divide by
// 1000 of the period scaling is a reciprocal product with a small correction. A sample
// holds the input side until its result is written to the output register, which can
// wait for the output register; the result is held there, and the next item may be taken
// while it waits. Attractor, constraint-force, field- and external-force items load the
// gains first; a gain write goes straight to the gain memory as it is taken. All Q16.16
// arithmetic is signed two's complement; products round toward minus infinity, quotients
// toward zero, and every stored or emitted value saturates to 32 bits. The first sample
// of a joint sets its attractor and previous position to the sample, so its velocity is
// zero.
module joint_attractor_velocity_control_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [3:0]         joint,
  input  logic signed [31:0] value,
  input  logic [30:0]        vector_magnitude,
  input  logic [3:0]         gain_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_joint,
  output logic signed [31:0] velocity_command,
  output logic signed [31:0] normalized_position,
  output logic               apply_command
);
  import jav_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_E_MUL, S_NORM, S_VEL, S_TFX, S_FX_MUL, S_FX_DIV, S_LIM_MUL, S_LIM_DIV,
    S_CV_MUL, S_ACC, S_APER_MUL, S_RCP_MUL, S_RCP_FIX, S_RCP_ADD, S_SQ_MUL, S_SQ_CHK,
    S_C1_MUL, S_C1_GET, S_C2_MUL, S_C2_GET, S_F_T, S_F_MUL, S_F_DIV
  } state_t;

  state_t state;

  // config
  logic [9:0] period_ms;
  logic       drive_enable;
  logic [9:0] per;

  // captured item
  logic [2:0]         cmd_r;
  logic [3:0]         j_r;
  logic signed [31:0] val_r;
  logic [30:0]        mag_r;
  logic [JOINT_W-1:0] j_idx;

  // per-joint state
  logic signed [31:0] attractor         [JOINTS];
  logic signed [31:0] previous_position [JOINTS];
  logic signed [31:0] constraint_force  [JOINTS];
  logic signed [31:0] field_force       [JOINTS];
  logic signed [31:0] external_force    [JOINTS];
  logic [JOINTS-1:0]  joint_seen;

  // gain memory and the gain bank of the current joint
  logic signed [31:0] gain_mem [JOINTS*NGAIN];
  logic signed [31:0] gain_rd;
  logic signed [31:0] gain_r [NGAIN];
  logic [GADDR_W-1:0] gbase;
  logic [GADDR_W-1:0] rd_addr;
  logic [GADDR_W-1:0] wr_addr;
  logic               gain_we;
  logic [3:0]         load_cnt;

  // working registers
  logic signed [31:0] e_r, norm_r, v_r, t_r, fx_r, flim_r, a_r, ctrl_r;
  logic               div_sent;

  // a*period/1000: magnitude, sign and corrected quotient magnitude
  logic [40:0]        y_r;
  logic               neg_r;
  logic [32:0]        qa_r;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 div_req;
  logic                     div_busy, div_done;
  logic signed [31:0]       div_quo;

  // combinational helpers
  logic               accept, joint_ok;
  logic signed [31:0] prod_q;
  logic signed [63:0] range, lo, hi, qv;
  logic               below, above;
  logic signed [31:0] lim_arg, abs_e, fmax, kf;
  logic signed [31:0] n_clamp, f_clamp;
  logic signed [63:0] acc_sum;
  logic [63:0]        y_mag;
  logic [31:0]        q0;
  logic [40:0]        q0_x1000;
  logic [11:0]        rem_lo;
  logic [1:0]         q_fix;

  assign per      = (period_ms == 10'd0) ? 10'd1 : period_ms;
  assign j_idx    = j_r[JOINT_W-1:0];
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign joint_ok = 32'(joint) < JOINTS;

  assign prod_q = sat32(prod >>> FRAC_BITS);
  assign range  = 64'(gain_r[G_MAX]) - 64'(gain_r[G_MIN]);
  assign qv     = 64'(val_r);
  assign lo     = 64'(gain_r[G_MIN]) + 64'(gain_r[G_KFLIM]);
  assign hi     = 64'(gain_r[G_MAX]) - 64'(gain_r[G_KFLIM]);
  assign below  = qv < lo;
  assign above  = qv > hi;
  assign lim_arg = below ? sat32(lo - qv) : sat32(hi - qv);
  assign abs_e  = (e_r == 32'sh80000000) ? 32'sh7fffffff : (e_r[31] ? -e_r : e_r);
  assign fmax   = (cmd_r == CMD_FIELD) ? gain_r[G_FFLDMAX] : gain_r[G_FRPCMAX];
  assign kf     = (cmd_r == CMD_FIELD) ? gain_r[G_KFFLD]   : gain_r[G_KFRPC];
  assign n_clamp = val_r[31] ? 32'sd0 : ((val_r > QONE) ? QONE : val_r);
  assign f_clamp = (val_r > QONE) ? QONE : ((val_r < -QONE) ? -QONE : val_r);
  assign acc_sum = -64'(prod_q) + 64'(fx_r) + 64'(flim_r) + 64'(constraint_force[j_idx])
                 + 64'(field_force[j_idx]) + 64'(external_force[j_idx]);

  // divide by 1000: estimate from the top bits, undershoots by at most 3
  assign y_mag    = prod[63] ? 64'(-prod) : 64'(prod);
  assign q0       = prod[62:31];
  assign q0_x1000 = (41'(q0) << 10) - (41'(q0) << 4) - (41'(q0) << 3);
  assign rem_lo   = 12'(y_r - q0_x1000);
  assign q_fix    = {1'b0, rem_lo >= 12'd1000} + {1'b0, rem_lo >= 12'd2000}
                  + {1'b0, rem_lo >= 12'd3000};

  // gain memory addressing
  assign gbase   = GADDR_W'(j_r) * GADDR_W'(NGAIN);
  assign rd_addr = (load_cnt < 4'(NGAIN)) ? gbase + GADDR_W'(load_cnt) : gbase;
  assign wr_addr = GADDR_W'(joint) * GADDR_W'(NGAIN) + GADDR_W'(gain_select);
  assign gain_we = accept && joint_ok && (cmd == CMD_GAIN) && (gain_select < 4'(NGAIN));

  always_ff @(posedge clk) begin
    if (gain_we) gain_mem[wr_addr] <= value;
    gain_rd <= gain_mem[rd_addr];
  end

  // operand steering for the shared multiplier and divider
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    unique case (state)
      S_E_MUL: begin
        mul_a = MUL_W'(gain_r[G_W]);
        mul_b = MUL_W'(sat32(64'(attractor[j_idx]) - qv));
      end
      S_NORM: begin
        div_req.start = !div_sent && (range != 64'sd0);
        div_req.num   = (qv - 64'(gain_r[G_MIN])) <<< FRAC_BITS;
        div_req.den   = range;
      end
      S_VEL: begin
        div_req.start = !div_sent;
        div_req.num   = (qv - 64'(previous_position[j_idx])) * 64'sd1000;
        div_req.den   = 64'(per);
      end
      S_TFX: begin
        div_req.start = !div_sent;
        div_req.num   = 64'(gain_r[G_FXMAX]) <<< FRAC_BITS;
        div_req.den   = 64'(gain_r[G_K]);
      end
      S_FX_MUL: begin
        mul_a = MUL_W'(gain_r[G_FXMAX]);
        mul_b = MUL_W'(e_r);
      end
      S_FX_DIV: begin
        div_req.start = !div_sent;
        div_req.num   = prod;
        div_req.den   = 64'(t_r) + 64'(abs_e);
      end
      S_LIM_MUL: begin
        mul_a = MUL_W'(gain_r[G_FLIMMAX]);
        mul_b = MUL_W'(lim_arg);
      end
      S_LIM_DIV: begin
        div_req.start = !div_sent;
        div_req.num   = prod;
        div_req.den   = 64'(gain_r[G_KFLIM]);
      end
      S_CV_MUL: begin
        mul_a = MUL_W'(gain_r[G_C]);
        mul_b = MUL_W'(v_r);
      end
      S_APER_MUL: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'($signed({1'b0, per}));
      end
      S_RCP_MUL: begin
        mul_a = MUL_W'(y_mag[40:9]);
        mul_b = MUL_W'(RCP_1000);
      end
      S_SQ_MUL, S_SQ_CHK: begin
        // operands held so the square stays valid while the output slot is busy
        mul_a = MUL_W'(ctrl_r);
        mul_b = MUL_W'(ctrl_r);
      end
      S_C1_MUL: begin
        mul_a = MUL_W'(n_clamp);
        mul_b = MUL_W'(range);
      end
      S_C2_MUL: begin
        mul_a = MUL_W'(f_clamp);
        mul_b = MUL_W'(gain_r[G_FCSTMAX]);
      end
      S_F_T: begin
        div_req.start = !div_sent;
        div_req.num   = 64'(fmax) <<< FRAC_BITS;
        div_req.den   = 64'(kf);
      end
      S_F_MUL: begin
        mul_a = MUL_W'(fmax);
        mul_b = MUL_W'(val_r);
      end
      S_F_DIV: begin
        div_req.start = !div_sent;
        div_req.num   = prod;
        div_req.den   = 64'(t_r) + 64'(mag_r);
      end
      default: ;
    endcase
  end

  jav_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  jav_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms    <= 10'd10;
      drive_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD: period_ms    <= cfg_data;
        CFG_DRIVE:  drive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, per-joint state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      div_sent   <= 1'b0;
      load_cnt   <= 4'd0;
      joint_seen <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        constraint_force[i] <= 32'sd0;
        field_force[i]      <= 32'sd0;
        external_force[i]   <= 32'sd0;
      end
    end else begin
      // the final step refills the slot itself
      if (out_valid && out_ready && state != S_SQ_CHK) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept && joint_ok) begin
            cmd_r    <= cmd;
            j_r      <= joint;
            val_r    <= value;
            mag_r    <= vector_magnitude;
            load_cnt <= 4'd0;
            if (cmd == CMD_SAMPLE && !joint_seen[joint[JOINT_W-1:0]]) begin
              // first sample pins attractor and history to the position
              joint_seen[joint[JOINT_W-1:0]]        <= 1'b1;
              attractor[joint[JOINT_W-1:0]]         <= value;
              previous_position[joint[JOINT_W-1:0]] <= value;
            end
            if (cmd == CMD_SAMPLE || cmd == CMD_ATTRACTOR || cmd == CMD_CONSTRAINT ||
                cmd == CMD_FIELD || cmd == CMD_EXTERNAL) begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          load_cnt <= load_cnt + 4'd1;
          if (load_cnt != 4'd0) gain_r[load_cnt - 4'd1] <= gain_rd;
          if (load_cnt == 4'(NGAIN)) begin
            priority case (cmd_r)
              CMD_SAMPLE:     state <= S_E_MUL;
              CMD_ATTRACTOR:  state <= S_C1_MUL;
              CMD_CONSTRAINT: state <= S_C2_MUL;
              default:        state <= S_F_T;
            endcase
          end
        end
        S_E_MUL: state <= S_NORM;
        S_NORM: begin
          if (!div_sent) begin
            e_r <= prod_q;
            if (range == 64'sd0) begin
              norm_r <= 32'sd0;
              state  <= S_VEL;
            end else begin
              div_sent <= 1'b1;
            end
          end else if (div_done) begin
            norm_r   <= div_quo;
            div_sent <= 1'b0;
            state    <= S_VEL;
          end
        end
        S_VEL: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            v_r      <= div_quo;
            div_sent <= 1'b0;
            state    <= S_TFX;
          end
        end
        S_TFX: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            t_r      <= div_quo;
            div_sent <= 1'b0;
            state    <= S_FX_MUL;
          end
        end
        S_FX_MUL: state <= S_FX_DIV;
        S_FX_DIV: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            fx_r     <= div_quo;
            div_sent <= 1'b0;
            state    <= S_LIM_MUL;
          end
        end
        S_LIM_MUL: begin
          if (below || above) begin
            state <= S_LIM_DIV;
          end else begin
            flim_r <= 32'sd0;
            state  <= S_CV_MUL;
          end
        end
        S_LIM_DIV: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            flim_r   <= div_quo;
            div_sent <= 1'b0;
            state    <= S_CV_MUL;
          end
        end
        S_CV_MUL: state <= S_ACC;
        S_ACC: begin
          a_r   <= sat32(acc_sum);
          state <= S_APER_MUL;
        end
        S_APER_MUL: state <= S_RCP_MUL;
        S_RCP_MUL: begin
          y_r   <= y_mag[40:0];
          neg_r <= prod[63];
          state <= S_RCP_FIX;
        end
        S_RCP_FIX: begin
          qa_r  <= 33'(q0) + 33'(q_fix);
          state <= S_RCP_ADD;
        end
        S_RCP_ADD: begin
          // quotient is not saturated before it joins the velocity
          ctrl_r <= sat32(64'(v_r) + (neg_r ? -64'(qa_r) : 64'(qa_r)));
          state  <= S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_CHK;
        S_SQ_CHK: begin
          // wait here until the previous beat has been taken
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_joint           <= j_r;
            velocity_command    <= (64'(prod) <= DEAD_THR) ? 32'sd0 : ctrl_r;
            normalized_position <= norm_r;
            apply_command       <= drive_enable;
            previous_position[j_idx] <= val_r;
            state               <= S_IDLE;
          end
        end
        S_C1_MUL: state <= S_C1_GET;
        S_C1_GET: begin
          attractor[j_idx] <= sat32(64'(gain_r[G_MIN]) + (prod >>> FRAC_BITS));
          state            <= S_IDLE;
        end
        S_C2_MUL: state <= S_C2_GET;
        S_C2_GET: begin
          constraint_force[j_idx] <= prod_q;
          state                   <= S_IDLE;
        end
        S_F_T: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            t_r      <= div_quo;
            div_sent <= 1'b0;
            state    <= S_F_MUL;
          end
        end
        S_F_MUL: state <= S_F_DIV;
        S_F_DIV: begin
          if (!div_sent) div_sent <= 1'b1;
          else if (div_done) begin
            if (cmd_r == CMD_FIELD) field_force[j_idx]    <= div_quo;
            else                    external_force[j_idx] <= div_quo;
            div_sent <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a division is never launched while the divider is still iterating
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // a new result beat only ever comes out of the dead-band check
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SQ_CHK))
    else $error("result raised outside the final step");

  // the gain load never runs past the bank
  a_load_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> load_cnt <= 4'(NGAIN))
    else $error("gain load counter overran");

endmodule

FILE: tb/tb_joint_attractor_velocity_control_unit.sv
// Self-checking testbench for the joint attractor velocity controller.
`timescale 1ns / 1ps
module tb_joint_attractor_velocity_control_unit;
  import jav_pkg::*;

  // Command codes that the block must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  // Settling time after the last result, with a margin for an item still in flight
  localparam int SETTLE_CYCLES = 700;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_BEATS  = 2000;

  typedef struct {
    logic [3:0]         jnt;
    logic signed [31:0] vel;
    logic signed [31:0] norm;
    logic               apply;
  } motor_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_PERIOD;
  logic [9:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd = CMD_SAMPLE;
  logic [3:0]         joint = '0;
  logic signed [31:0] value = '0;
  logic [30:0]        vector_magnitude = '0;
  logic [3:0]         gain_select = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_joint;
  logic signed [31:0] velocity_command;
  logic signed [31:0] normalized_position;
  logic               apply_command;

  joint_attractor_velocity_control_unit dut (.*);

  always #5 clk = ~clk;

  // Shadow of the controller state
  int          gains [JOINTS][NGAIN];
  int          attr [JOINTS];
  int          prev_pos [JOINTS];
  int          cst_force [JOINTS];
  int          fld_force [JOINTS];
  int          ext_force [JOINTS];
  bit          seen [JOINTS];
  int unsigned period_ms = 10;
  bit          drive_en = 1'b0;

  motor_cmd_t  cmd_forecast[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          samples_sent = 0;
  int          beats_sent = 0;
  bit          idle_on = 1'b1;
  logic        in_fire = 1'b0;
  int          stall_cnt = 0;

  // ---------------- fixed-point helpers ----------------
  function automatic int sat(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int mulq(int a, int b);
    return sat((longint'(a) * longint'(b)) >>> FRAC_BITS);  // floor
  endfunction

  function automatic int divz(longint n, longint d);
    if (d == 0) return (n > 0) ? 32'sh7fffffff : ((n < 0) ? 32'sh80000000 : 0);
    return sat(n / d);  // truncates toward zero
  endfunction

  function automatic int divq(int a, int b);
    return divz(longint'(a) * (64'sd1 <<< FRAC_BITS), longint'(b));
  endfunction

  function automatic int muldiv(int a, int b, longint d);
    return divz(longint'(a) * longint'(b), d);
  endfunction

  function automatic int absq(int x);
    return (x < 0) ? sat(-longint'(x)) : x;
  endfunction

  // Advance the shadow state for one accepted beat; queue the motor command for a sample
  function automatic void forecast_item(logic [2:0] c, int j, int v_in, longint mag,
                                        int sel);
    longint rng, per, lo, hi, sum, n, sq;
    int q, norm, e, vel, fx, flim, acc, ctrl, f;
    motor_cmd_t m;
    rng = longint'(gains[j][G_MAX]) - longint'(gains[j][G_MIN]);
    per = (period_ms == 0) ? 64'sd1 : longint'(period_ms);
    case (c)
      CMD_SAMPLE: begin
        q = v_in;
        if (!seen[j]) begin
          seen[j] = 1'b1;
          attr[j] = q;
          prev_pos[j] = q;
        end
        norm = (rng == 0) ? 0 :
               divz((longint'(q) - gains[j][G_MIN]) * (64'sd1 <<< FRAC_BITS), rng);
        e = mulq(gains[j][G_W], sat(longint'(attr[j]) - q));
        vel = divz(64'sd1000 * (longint'(q) - prev_pos[j]), per);
        fx = muldiv(gains[j][G_FXMAX], e,
                    longint'(divq(gains[j][G_FXMAX], gains[j][G_K])) + absq(e));
        lo = longint'(gains[j][G_MIN]) + gains[j][G_KFLIM];
        hi = longint'(gains[j][G_MAX]) - gains[j][G_KFLIM];
        if (longint'(q) < lo)
          flim = muldiv(gains[j][G_FLIMMAX], sat(lo - q), longint'(gains[j][G_KFLIM]));
        else if (longint'(q) > hi)
          flim = muldiv(gains[j][G_FLIMMAX], sat(hi - q), longint'(gains[j][G_KFLIM]));
        else
          flim = 0;
        sum = -longint'(mulq(gains[j][G_C], vel)) + fx + flim
              + cst_force[j] + fld_force[j] + ext_force[j];
        acc = sat(sum);
        ctrl = sat(longint'(vel) + (longint'(acc) * per) / 1000);
        sq = longint'(ctrl) * longint'(ctrl);
        if (sq <= longint'(DEAD_THR)) ctrl = 0;  // dead band
        prev_pos[j] = q;
        m.jnt = 4'(j);
        m.vel = ctrl;
        m.norm = norm;
        m.apply = drive_en;
        cmd_forecast.push_back(m);
      end
      CMD_ATTRACTOR: begin
        n = (v_in < 0) ? 0 : ((v_in > int'(QONE)) ? longint'(QONE) : longint'(v_in));
        attr[j] = sat(longint'(gains[j][G_MIN]) + ((n * rng) >>> FRAC_BITS));
      end
      CMD_CONSTRAINT: begin
        f = (v_in > int'(QONE)) ? int'(QONE) : ((v_in < -int'(QONE)) ? -int'(QONE) : v_in);
        cst_force[j] = mulq(f, gains[j][G_FCSTMAX]);
      end
      CMD_FIELD:
        fld_force[j] = muldiv(gains[j][G_FFLDMAX], v_in,
                              longint'(divq(gains[j][G_FFLDMAX], gains[j][G_KFFLD])) + mag);
      CMD_EXTERNAL:
        ext_force[j] = muldiv(gains[j][G_FRPCMAX], v_in,
                              longint'(divq(gains[j][G_FRPCMAX], gains[j][G_KFRPC])) + mag);
      CMD_GAIN:
        if (sel < NGAIN) gains[j][sel] = v_in;
      default: ;  // spare codes do nothing
    endcase
  endfunction

  // ---------------- handshake monitors ----------------
  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk)
    out_ready <= idle_on ? ($urandom_range(99) >= 6) : 1'b1;

  // Compare each result beat with the oldest queued motor command
  always @(posedge clk) begin
    motor_cmd_t m;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (cmd_forecast.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, joint %0d", out_joint);
      end else begin
        m = cmd_forecast.pop_front();
        if (out_joint !== m.jnt || velocity_command !== m.vel ||
            normalized_position !== m.norm || apply_command !== m.apply) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp j=%0d vel=%0d norm=%0d app=%0b, ",
                      "got j=%0d vel=%0d norm=%0d app=%0b"},
                     m.jnt, m.vel, m.norm, m.apply, out_joint, velocity_command,
                     normalized_position, apply_command);
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- driver tasks ----------------
  task automatic send_item(logic [2:0] c, int j, int v_in, logic [30:0] mag, int sel);
    int gap;
    if (idle_on && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    cmd = c;
    joint = 4'(j);
    value = v_in;
    vector_magnitude = mag;
    gain_select = 4'(sel);
    in_valid = 1'b1;
    do @(negedge clk); while (!in_fire);
    in_valid = 1'b0;
    forecast_item(c, j, v_in, longint'(mag), sel);
    beats_sent++;
    if (c == CMD_SAMPLE) samples_sent++;
  endtask

  // Wait until every queued result is out, then let any silent item finish
  task automatic drain();
    while (cmd_forecast.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [9:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_PERIOD) period_ms = data;
    else drive_en = data[0];
  endtask

  function automatic int rand_q16(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic int rand_gain(int sel);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 8) return int'($urandom);
    case (sel)
      G_MIN:   return -$urandom_range(3 * int'(QONE));
      G_MAX:   return $urandom_range(3 * int'(QONE));
      G_KFLIM: return $urandom_range(int'(QONE));
      default: return rand_q16(4 * int'(QONE));
    endcase
  endfunction

  function automatic int rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return int'($urandom);  // every bit toggles
    if (r < 13) return 32'sh7fffffff;
    if (r < 16) return 32'sh80000000;
    return rand_q16(4 * int'(QONE));
  endfunction

  function automatic logic [30:0] rand_mag();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 31'($urandom);
    if (r < 14) return 31'h7fffffff;
    if (r < 20) return '0;
    return 31'($urandom_range(8 * int'(QONE)));
  endfunction

  // ---------------- tests ----------------
  // Every gain of every joint is written before anything reads it
  task automatic test_gain_load();
    for (int j = 0; j < JOINTS; j++)
      for (int s = 0; s < NGAIN; s++)
        send_item(CMD_GAIN, j, rand_gain(s), '0, s);
  endtask

  task automatic test_directed();
    // attractor write on a fresh joint, then overridden by its first sample
    send_item(CMD_ATTRACTOR, 15, int'(QONE) / 2, '0, 0);
    send_item(CMD_SAMPLE, 15, int'(QONE), '0, 0);
    send_item(CMD_SAMPLE, 15, 32'sh7fffffff, '0, 0);
    send_item(CMD_SAMPLE, 15, 32'sh80000000, '0, 0);
    // attractor clamp below 0 and above 1
    send_item(CMD_ATTRACTOR, 15, -1, '0, 0);
    send_item(CMD_ATTRACTOR, 15, 32'sh7fffffff, '0, 0);
    // constraint clamp both ways, field and external with zero and full magnitude
    send_item(CMD_CONSTRAINT, 15, 32'sh80000000, '0, 0);
    send_item(CMD_CONSTRAINT, 15, 32'sh7fffffff, '0, 0);
    send_item(CMD_FIELD, 15, 32'sh7fffffff, '0, 0);
    send_item(CMD_EXTERNAL, 15, 32'sh80000000, 31'h7fffffff, 0);
    send_item(CMD_SAMPLE, 15, 0, '0, 0);
    // zero gains: divisions by zero, and max equal to min
    send_item(CMD_GAIN, 14, 0, '0, G_K);
    send_item(CMD_GAIN, 14, 0, '0, G_KFLIM);
    send_item(CMD_GAIN, 14, 0, '0, G_MIN);
    send_item(CMD_GAIN, 14, 0, '0, G_MAX);
    send_item(CMD_FIELD, 14, 0, '0, 0);
    send_item(CMD_SAMPLE, 14, int'(QONE), '0, 0);
    send_item(CMD_SAMPLE, 14, -int'(QONE), '0, 0);
    // spare commands and an out-of-table gain slot are ignored
    send_item(CMD_SPARE_A, 3, 32'sh7fffffff, 31'h7fffffff, 15);
    send_item(CMD_SPARE_B, 3, 32'sh80000000, '0, 0);
    send_item(CMD_GAIN, 3, 32'sh12345678, '0, 13);
    send_item(CMD_SAMPLE, 3, 32'sh0000ffff, '0, 0);
  endtask

  task automatic test_random_phase(int beats);
    int r, sel;
    logic [2:0] c;
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      sel = 0;
      if (r < 45) c = CMD_SAMPLE;
      else if (r < 53) c = CMD_ATTRACTOR;
      else if (r < 61) c = CMD_CONSTRAINT;
      else if (r < 69) c = CMD_FIELD;
      else if (r < 77) c = CMD_EXTERNAL;
      else if (r < 95) begin
        c = CMD_GAIN;
        sel = $urandom_range(15);
      end else c = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
      send_item(c, $urandom_range(JOINTS - 1),
                (c == CMD_GAIN && sel < NGAIN) ? rand_gain(sel) : rand_value(),
                rand_mag(), sel);
    end
  endtask

  // Period extremes, zero period and drive enable both ways
  task automatic test_config_sweep();
    drain();
    write_cfg(CFG_PERIOD, 10'd1000);
    write_cfg(CFG_DRIVE, 1'b1);
    test_random_phase(RANDOM_BEATS / 4);
    drain();
    write_cfg(CFG_PERIOD, 10'd0);
    test_random_phase(RANDOM_BEATS / 4);
    drain();
    write_cfg(CFG_PERIOD, 10'd1);
    write_cfg(CFG_DRIVE, 1'b0);
    idle_on = 1'b0;  // a stretch without idling on either side
    test_random_phase(RANDOM_BEATS / 4);
    idle_on = 1'b1;
    drain();
    write_cfg(CFG_PERIOD, 10'($urandom_range(2, 1023)));
    write_cfg(CFG_DRIVE, 1'b1);
    test_random_phase(RANDOM_BEATS / 4);
  endtask

  initial begin
    for (int j = 0; j < JOINTS; j++) begin
      attr[j] = 0;
      prev_pos[j] = 0;
      cst_force[j] = 0;
      fld_force[j] = 0;
      ext_force[j] = 0;
      seen[j] = 1'b0;
      for (int s = 0; s < NGAIN; s++) gains[j][s] = 0;
    end
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_gain_load();
    test_directed();
    test_config_sweep();
    drain();
    $display("covered %0d beats, %0d samples, %0d motor commands checked",
             beats_sent, samples_sent, results_seen);
    $display("periods 10, 1000, 0, 1 and random; drive enable on and off");
    if (mismatches == 0 && cmd_forecast.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, cmd_forecast.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: joint_attractor_velocity_control_unit.f
src/jav_pkg.sv
src/jav_mul.sv
src/jav_div.sv
src/joint_attractor_velocity_control_unit.sv
tb/tb_joint_attractor_velocity_control_unit.sv
